[rtl/core/msp_rx_pkg.sv]
package msp_rx_pkg;

  localparam logic [7:0] START_BYTE        = 8'h24;  // '$'
  localparam logic [7:0] VERSION_BYTE      = 8'h4D;  // 'M'
  localparam logic [7:0] DEFAULT_DIRECTION = 8'h3C;  // '<'

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_VERSION,
    PH_DIRECTION,
    PH_SIZE,
    PH_COMMAND,
    PH_PAYLOAD,
    PH_CHECK
  } phase_e;

  // classified word handed from front to back
  typedef enum logic [1:0] {
    OP_SIZE,
    OP_COMMAND,
    OP_DATA,
    OP_CHECK
  } op_e;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_OK,
    KIND_BAD
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  word;
  } op_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] command_code;
    logic [7:0] frame_length;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } result_t;

endpackage

[rtl/core/msp_rx_front.sv]
module msp_rx_front
  import msp_rx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       cfg_valid_i,
  input  logic [7:0] cfg_data_i,
  output op_word_t   op_o
);

  phase_e     phase_q, phase_d;
  logic       header_good_q, header_good_d;
  logic [7:0] len_q, len_d;
  logic [7:0] count_q, count_d;
  logic [7:0] dir_q;
  logic [7:0] count_inc;

  assign count_inc = count_q + 8'd1;

  // next state
  always_comb begin
    phase_d       = phase_q;
    header_good_d = header_good_q;
    len_d         = len_q;
    count_d       = count_q;
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == START_BYTE) phase_d = PH_VERSION;
        end
        PH_VERSION: begin
          header_good_d = (rx_byte_i == VERSION_BYTE);
          phase_d       = PH_DIRECTION;
        end
        PH_DIRECTION: begin
          phase_d = (header_good_q && rx_byte_i == dir_q) ? PH_SIZE : PH_HUNT;
        end
        PH_SIZE: begin
          len_d   = rx_byte_i;
          phase_d = PH_COMMAND;
        end
        PH_COMMAND: begin
          count_d = 8'd0;
          phase_d = (len_q == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          count_d = count_inc;
          if (count_inc == len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          phase_d = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    op_o.valid     = 1'b0;
    op_o.word.op   = OP_DATA;
    op_o.word.data = rx_byte_i;
    unique case (phase_q)
      PH_SIZE: begin
        op_o.valid   = accept_i;
        op_o.word.op = OP_SIZE;
      end
      PH_COMMAND: begin
        op_o.valid   = accept_i;
        op_o.word.op = OP_COMMAND;
      end
      PH_PAYLOAD: begin
        op_o.valid   = accept_i;
        op_o.word.op = OP_DATA;
      end
      PH_CHECK: begin
        op_o.valid   = accept_i;
        op_o.word.op = OP_CHECK;
      end
      default: begin
        op_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HUNT;
      header_good_q <= 1'b0;
      len_q         <= 8'd0;
      count_q       <= 8'd0;
      dir_q         <= DEFAULT_DIRECTION;
    end else begin
      phase_q       <= phase_d;
      header_good_q <= header_good_d;
      len_q         <= len_d;
      count_q       <= count_d;
      if (cfg_valid_i) dir_q <= cfg_data_i;
    end
  end

endmodule

[rtl/core/msp_rx_queue.sv]
module msp_rx_queue
  import msp_rx_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  op_word_t      wr_i,
  input  logic          rd_i,
  output op_t           head_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t             slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_wr  = wr_i.valid && !status_o.full;
  assign do_rd  = rd_i && !status_o.empty;
  assign head_o = slots_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_wr) slots_q[wr_ptr_q] <= wr_i.word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wrap_inc(wr_ptr_q);
      if (do_rd) rd_ptr_q <= wrap_inc(rd_ptr_q);
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/core/msp_rx_back.sv]
module msp_rx_back
  import msp_rx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  op_t     head_i,
  input  logic    head_empty_i,
  output logic    head_pop_o,
  input  logic    pop_i,
  output logic    empty_o,
  output result_t result_o
);

  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic [7:0] chk_q, cmd_q, len_q, idx_q;
  logic       makes_result, out_free, take;

  assign makes_result = (head_i.op == OP_DATA) || (head_i.op == OP_CHECK);
  assign out_free     = !out_valid_q || pop_i;
  assign take         = !head_empty_i && (!makes_result || out_free);
  assign head_pop_o   = take;
  assign empty_o      = !out_valid_q;
  assign result_o     = out_q;

  // output word held until popped, refilled by a data or check word
  always_comb begin
    out_valid_d = out_valid_q && !pop_i;
    if (take && makes_result) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      chk_q       <= 8'd0;
      cmd_q       <= 8'd0;
      len_q       <= 8'd0;
      idx_q       <= 8'd0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        unique case (head_i.op)
          OP_SIZE: begin
            len_q <= head_i.data;
            chk_q <= head_i.data;
          end
          OP_COMMAND: begin
            cmd_q <= head_i.data;
            chk_q <= chk_q ^ head_i.data;
            idx_q <= 8'd0;
          end
          OP_DATA: begin
            chk_q <= chk_q ^ head_i.data;
            idx_q <= idx_q + 8'd1;
          end
          OP_CHECK: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    if (take && makes_result) begin
      out_q.command_code <= cmd_q;
      out_q.frame_length <= len_q;
      if (head_i.op == OP_DATA) begin
        out_q.kind          <= KIND_DATA;
        out_q.payload_byte  <= head_i.data;
        out_q.payload_index <= idx_q;
      end else begin
        out_q.kind          <= (head_i.data == chk_q) ? KIND_OK : KIND_BAD;
        out_q.payload_byte  <= 8'd0;
        out_q.payload_index <= 8'd0;
      end
    end
  end

endmodule

[rtl/core/msp_v1_frame_receiver.sv]
// MSP v1 request frame receiver.
// Input channel: one serial byte per word on rx_byte_i, taken at a rising edge
// with push high and full low. Result channel: a queue read port; while
// empty is low the oldest result sits on kind_o, command_code_o,
// frame_length_o, payload_byte_o and payload_index_o, and is taken at an edge
// with pop high. Results: one per payload byte, plus one end word (frame
// accepted or checksum mismatch) at the checksum byte; header bytes give none.
// Config channel: cfg_valid_i/cfg_ready_o carry the expected direction byte;
// ready is always high, write it only while the block is idle.
// Throughput: one byte per cycle while full is low, set by the front deframer FSM
// taking a word each cycle and the back stage retiring one queue word each cycle
// while its output register is free. Path: a payload or checksum byte is written
// to the queue at the edge that takes it, then moves into the output register.
// When the receiver stalls, the output register holds and the QueueDepth-word
// queue fills; full rises once it is full and then holds off every byte,
// header bytes included, until the back stage frees a slot.
// Reset: asynchronous, active low; hunts for '$', direction resets to '<',
// queue and output register empty.
module msp_v1_frame_receiver
  import msp_rx_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // results
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind_o,
  output logic [7:0] command_code_o,
  output logic [7:0] frame_length_o,
  output logic [7:0] payload_byte_o,
  output logic [7:0] payload_index_o
);

  op_word_t      front_word;
  op_t           q_head;
  queue_status_t q_stat;
  logic          q_pop;
  logic          accept;
  result_t       res;

  assign full        = q_stat.full;
  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  // front: deframing FSM, classifies each byte
  msp_rx_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .op_o        (front_word)
  );

  // decoupling queue between the two halves
  msp_rx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (front_word),
    .rd_i     (q_pop),
    .head_o   (q_head),
    .status_o (q_stat)
  );

  // back: checksum, indexing and the output register
  msp_rx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_empty_i (q_stat.empty),
    .head_pop_o   (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .result_o     (res)
  );

  assign kind_o          = res.kind;
  assign command_code_o  = res.command_code;
  assign frame_length_o  = res.frame_length;
  assign payload_byte_o  = res.payload_byte;
  assign payload_index_o = res.payload_index;

`ifndef SYNTH
  // a full queue is never also flagged empty
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !q_stat.empty)
    else $error("queue full and empty at once");

  // end words carry zero byte and index
  a_end_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_DATA) |->
      (payload_byte_o == 8'd0 && payload_index_o == 8'd0))
    else $error("end word with non-zero byte or index");

  // draining the last result with nothing queued leaves the output empty
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && q_stat.empty) |=> empty)
    else $error("result appeared without a queued word");
`endif

endmodule

[bench/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msp_rx_pkg::*;

  // Run limits.
  localparam int unsigned CYCLE_LIMIT  = 300000;
  // Quiet cycles after the last result before a direction write or the end.
  localparam int unsigned SETTLE_EDGES = 8;
  // Long receiver hold-off used to fill the result queue.
  localparam int unsigned HOLD_EDGES   = 200;
  localparam int unsigned IDLE_PCT     = 27;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Block inputs, all known from time zero
  logic       push        = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       pop         = 1'b0;

  // Block outputs
  logic       full;
  logic       cfg_ready_o;
  logic       empty;
  logic [1:0] kind_o;
  logic [7:0] command_code_o;
  logic [7:0] frame_length_o;
  logic [7:0] payload_byte_o;
  logic [7:0] payload_index_o;

  msp_v1_frame_receiver dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .rx_byte_i      (rx_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .command_code_o (command_code_o),
    .frame_length_o (frame_length_o),
    .payload_byte_o (payload_byte_o),
    .payload_index_o(payload_index_o)
  );

  // ---------------------------------------------------------------------------
  // Deframer model: own copy of the parser state and the direction register.
  // ---------------------------------------------------------------------------
  phase_e     rx_phase    = PH_HUNT;
  bit         header_ok   = 1'b0;
  logic [7:0] frame_len   = 8'h00;
  logic [7:0] frame_cmd   = 8'h00;
  logic [7:0] payload_pos = 8'h00;
  logic [7:0] running_xor = 8'h00;
  logic [7:0] want_dir    = DEFAULT_DIRECTION;

  // Results the block still owes us, oldest first
  result_t    owed_results[$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned frame_words = 0;  // words sent inside frames or broken headers
  bit          steady      = 1'b0;  // no random idling on either side while set
  int unsigned hold_left   = 0;     // receiver hold-off, counted down per edge

  // Advances the model by one accepted byte; returns 1 with the result it gives.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    bit gives;
    gives = 1'b0;
    res   = '0;
    case (rx_phase)
      PH_HUNT: begin
        if (b == START_BYTE) rx_phase = PH_VERSION;
      end
      PH_VERSION: begin
        // version is only judged once the direction byte has also gone by
        header_ok = (b == VERSION_BYTE);
        rx_phase  = PH_DIRECTION;
      end
      PH_DIRECTION: begin
        rx_phase = (header_ok && b == want_dir) ? PH_SIZE : PH_HUNT;
      end
      PH_SIZE: begin
        frame_len   = b;
        running_xor = b;
        rx_phase    = PH_COMMAND;
      end
      PH_COMMAND: begin
        frame_cmd   = b;
        running_xor = running_xor ^ b;
        payload_pos = 8'h00;
        // an empty frame goes straight to its checksum
        rx_phase    = (frame_len == 8'h00) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.kind          = KIND_DATA;
        res.command_code  = frame_cmd;
        res.frame_length  = frame_len;
        res.payload_byte  = b;
        res.payload_index = payload_pos;
        gives             = 1'b1;
        running_xor       = running_xor ^ b;
        payload_pos       = payload_pos + 8'd1;
        if (payload_pos == frame_len) rx_phase = PH_CHECK;
      end
      PH_CHECK: begin
        res.kind         = (b == running_xor) ? KIND_OK : KIND_BAD;
        res.command_code = frame_cmd;
        res.frame_length = frame_len;
        gives            = 1'b1;
        rx_phase         = PH_HUNT;
      end
      default: rx_phase = PH_HUNT;
    endcase
    return gives;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offers one word, waits for the handshake, then books the result.
  // push is left high on return so back-to-back words need no second NBA.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b);
    result_t res;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    if (deframe_byte(b, res)) owed_results.push_back(res);
  endtask

  // Well-formed request with random payload; corrupt spoils the checksum.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] d;
    sum = len ^ cmd;
    send_word(START_BYTE);
    send_word(VERSION_BYTE);
    send_word(want_dir);
    send_word(len);
    send_word(cmd);
    for (int i = 0; i < len; i++) begin
      d   = 8'($urandom_range(0, 255));
      sum = sum ^ d;
      send_word(d);
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_word(sum);
    frame_words += len + 6;
  endtask

  // Lower push, wait for every owed result, then let the block sit quiet.
  task automatic settle();
    push <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_EDGES) @(posedge clk_i);
  endtask

  // Direction register write, only ever issued with the block idle.
  task automatic write_direction(input logic [7:0] d);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    want_dir     = d;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and result check. pop is redrawn every edge; a hold-off request
  // forces it low until hold_left, counted down here, reaches zero.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result word, expected none, got kind %0d cmd %0d",
                   $time, kind_o, command_code_o);
        end else begin
          want = owed_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(kind_o));
          check_field("command_code", want.command_code, command_code_o);
          check_field("frame_length", want.frame_length, frame_length_o);
          check_field("payload_byte", want.payload_byte, payload_byte_o);
          check_field("payload_index", want.payload_index, payload_index_o);
        end
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        pop      <= 1'b0;
      end else begin
        pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Junk while hunting gives nothing; empty frame at the reset direction.
  task automatic test_hunting_and_empty_frame();
    send_word(8'h00);
    send_word(8'hFF);
    send_word(START_BYTE);
    send_word(VERSION_BYTE);
    send_word(DEFAULT_DIRECTION);
    send_word(8'h00);  // size
    send_word(8'h05);  // command
    send_word(8'h05);  // checksum: 0 ^ 5
    settle();
  endtask

  // Bad version, then bad direction: both header bytes are eaten, no result.
  task automatic test_bad_headers();
    send_word(START_BYTE);
    send_word(8'h6D);
    send_word(DEFAULT_DIRECTION);
    send_word(START_BYTE);
    send_word(VERSION_BYTE);
    send_word(8'h3E);
    settle();
  endtask

  // Extreme payload values, a start byte inside the payload, bad checksum.
  task automatic test_payload_and_mismatch();
    send_word(START_BYTE);
    send_word(VERSION_BYTE);
    send_word(DEFAULT_DIRECTION);
    send_word(8'h03);
    send_word(8'hFF);
    send_word(8'h00);
    send_word(START_BYTE);
    send_word(8'hFF);
    send_word(8'h00);  // proper sum would be 8'h27
    settle();
  endtask

  // Direction register at '>' and at both extremes; the old '<' is refused.
  task automatic test_direction_settings();
    write_direction(8'h3E);
    send_word(START_BYTE);
    send_word(VERSION_BYTE);
    send_word(DEFAULT_DIRECTION);
    send_frame(8'h02, 8'h64, 1'b0);
    write_direction(8'h00);
    send_frame(8'h01, 8'h00, 1'b0);
    write_direction(8'hFF);
    send_frame(8'h01, 8'hFF, 1'b1);
    write_direction(DEFAULT_DIRECTION);
    settle();
  endtask

  // Receiver holds off while a longest frame streams in: queue fills,
  // full rises and the sender stalls. Also reaches payload index 254.
  task automatic test_receiver_hold();
    steady    = 1'b1;
    hold_left = HOLD_EDGES;
    send_frame(8'hFF, 8'($urandom_range(0, 255)), 1'b0);
    steady    = 1'b0;
    settle();
  endtask

  // Mostly well-formed frames with random content, some noise and broken headers.
  task automatic random_traffic(input int unsigned words);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  b;
    start = frame_words;
    while (frame_words - start < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        pick = $urandom_range(0, 99);
        if (pick < 2)       len = 8'hFF;
        else if (pick < 10) len = 8'($urandom_range(13, 255));
        else                len = 8'($urandom_range(0, 12));
        send_frame(len, 8'($urandom_range(0, 255)), $urandom_range(0, 99) < 25);
      end else if (pick < 90) begin
        // line noise while hunting, never a start byte
        do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
        send_word(b);
      end else begin
        send_word(START_BYTE);
        if ($urandom_range(0, 1) == 0) begin
          do b = 8'($urandom_range(0, 255)); while (b == VERSION_BYTE);
          send_word(b);
          send_word(want_dir);
        end else begin
          send_word(VERSION_BYTE);
          send_word(want_dir ^ 8'($urandom_range(1, 255)));
        end
        frame_words += 3;
      end
    end
  endtask

  // Random phases under several direction settings, one with no idling.
  task automatic test_random_traffic();
    random_traffic(160);
    write_direction(8'h3E);
    random_traffic(160);
    write_direction(8'h00);
    steady = 1'b1;
    random_traffic(160);
    steady = 1'b0;
    write_direction(8'hFF);
    random_traffic(160);
    write_direction(8'($urandom_range(0, 255)));
    random_traffic(80);
    write_direction(DEFAULT_DIRECTION);
    random_traffic(80);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_hunting_and_empty_frame();
    test_bad_headers();
    test_payload_and_mismatch();
    test_direction_settings();
    test_receiver_hold();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
